// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property shorthands for the two-set engine RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define CHECK_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, held off during reset.
`define CHECK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== src/bts_pkg.sv =====
// ----------------------------------------------------------------------------
// Two-set engine package
// Field widths, operation and status codes, channel and cell control types.
// ----------------------------------------------------------------------------
package bts_pkg;

   localparam int DATA_W       = 32;
   localparam int COUNT_W      = 7;
   localparam int OP_W         = 3;
   localparam int STATUS_W     = 2;
   localparam int CELL_OP_W    = 2;
   localparam int DEF_CAPACITY = 64;
   localparam int GROUP        = 8;

   localparam logic [OP_W-1:0] OP_ADD       = 3'd0;
   localparam logic [OP_W-1:0] OP_REMOVE    = 3'd1;
   localparam logic [OP_W-1:0] OP_QUERY     = 3'd2;
   localparam logic [OP_W-1:0] OP_EQUAL     = 3'd3;
   localparam logic [OP_W-1:0] OP_INTERSECT = 3'd4;
   localparam logic [OP_W-1:0] OP_UNION     = 3'd5;

   localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_PRESENT = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_ABSENT  = 2'd3;

   localparam logic [CELL_OP_W-1:0] CELL_HOLD   = 2'd0;
   localparam logic [CELL_OP_W-1:0] CELL_WRITE  = 2'd1;
   localparam logic [CELL_OP_W-1:0] CELL_SHIFT  = 2'd2;
   localparam logic [CELL_OP_W-1:0] CELL_ROTATE = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]          operation;
      logic                     which_set;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic                     flag;
      logic signed [DATA_W-1:0] element;
      logic                     element_valid;
      logic                     last;
      logic [COUNT_W-1:0]       set_count;
   } rsp_type;

   typedef struct packed {
      logic [CELL_OP_W-1:0] a_op;
      logic [CELL_OP_W-1:0] b_op;
      logic                 tgt_b;
      logic                 match_en;
      logic [COUNT_W-1:0]   a_count;
      logic [COUNT_W-1:0]   b_count;
      logic [COUNT_W-1:0]   idx;
      logic [DATA_W-1:0]    key;
   } cell_ctrl_type;

endpackage

// ===== src/bts_cell.sv =====
// ----------------------------------------------------------------------------
// Two-set engine cell
// Holds entry INDEX of set A and of set B, compares one of them with the key.
// ----------------------------------------------------------------------------
module bts_cell #(
   parameter int INDEX = 0
) (
   input  logic                         clock,
   input  bts_pkg::cell_ctrl_type       ctrl,
   input  logic [bts_pkg::DATA_W-1:0]   a_next,
   input  logic [bts_pkg::DATA_W-1:0]   b_next,
   input  logic [bts_pkg::DATA_W-1:0]   a_first,
   input  logic [bts_pkg::DATA_W-1:0]   b_first,
   output logic [bts_pkg::DATA_W-1:0]   a_value,
   output logic [bts_pkg::DATA_W-1:0]   b_value,
   output logic                         match
);
   import bts_pkg::*;

   localparam logic [COUNT_W-1:0] POS      = COUNT_W'(INDEX);
   localparam logic [COUNT_W-1:0] POS_NEXT = COUNT_W'(INDEX + 1);

   logic [DATA_W-1:0]  a_ff, a_in;
   logic [DATA_W-1:0]  b_ff, b_in;
   logic               match_ff, match_in;
   logic [DATA_W-1:0]  tgt;
   logic [COUNT_W-1:0] tgt_count;

   function automatic logic [DATA_W-1:0] next_entry(
      input logic [CELL_OP_W-1:0] op,
      input logic [DATA_W-1:0]    cur,
      input logic [DATA_W-1:0]    nxt,
      input logic [DATA_W-1:0]    first,
      input logic [COUNT_W-1:0]   count,
      input logic [DATA_W-1:0]    key,
      input logic [COUNT_W-1:0]   idx
   );
      logic [DATA_W-1:0] r;
      r = cur;
      unique case (op)
         CELL_HOLD: begin
            r = cur;
         end
         CELL_WRITE: begin
            if (POS == count) r = key;
         end
         CELL_SHIFT: begin
            if (POS >= idx && POS_NEXT < count) r = nxt;
         end
         CELL_ROTATE: begin
            // The ring closes at the last occupied entry.
            if (POS_NEXT < count) r = nxt;
            else if (POS_NEXT == count) r = first;
         end
      endcase
      return r;
   endfunction

   always_comb begin
      a_in      = next_entry(ctrl.a_op, a_ff, a_next, a_first, ctrl.a_count, ctrl.key,
                             ctrl.idx);
      b_in      = next_entry(ctrl.b_op, b_ff, b_next, b_first, ctrl.b_count, ctrl.key,
                             ctrl.idx);
      tgt       = ctrl.tgt_b ? b_ff : a_ff;
      tgt_count = ctrl.tgt_b ? ctrl.b_count : ctrl.a_count;
      match_in  = ctrl.match_en ? ((tgt == ctrl.key) && (POS < tgt_count)) : match_ff;
   end

   always_ff @(posedge clock) begin
      a_ff     <= a_in;
      b_ff     <= b_in;
      match_ff <= match_in;
   end

   assign a_value = a_ff;
   assign b_value = b_ff;
   assign match   = match_ff;

endmodule

// ===== src/bts_reduce.sv =====
// ----------------------------------------------------------------------------
// Two-set engine match reduction
// Registers per-group hit bits and the encoded position of the matching cell.
// ----------------------------------------------------------------------------
module bts_reduce #(
   parameter int CAPACITY = bts_pkg::DEF_CAPACITY
) (
   input  logic                                                  clock,
   input  logic                                                  en,
   input  logic [CAPACITY-1:0]                                   match,
   output logic [(CAPACITY+bts_pkg::GROUP-1)/bts_pkg::GROUP-1:0] grp,
   output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0]    idx
);
   import bts_pkg::*;

   localparam int NG = (CAPACITY + GROUP - 1) / GROUP;
   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   logic [NG-1:0] grp_ff, grp_in;
   logic [IW-1:0] idx_ff, idx_in;

   // Entries are distinct, so at most one bit is set and OR-ing positions encodes it.
   always_comb begin
      grp_in = '0;
      idx_in = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (match[i]) begin
            grp_in[i / GROUP] = 1'b1;
            idx_in            = idx_in | IW'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         grp_ff <= grp_in;
         idx_ff <= idx_in;
      end
   end

   assign grp = grp_ff;
   assign idx = idx_ff;

endmodule

// ===== src/bounded_two_set_engine_unit.sv =====
// ----------------------------------------------------------------------------
// Bounded two-set engine
// Two ordered sets of distinct 32-bit values kept in a chain of cells.
// ----------------------------------------------------------------------------
// Usage: items arrive on the req_ channel (operation, which_set, value) and
// results leave on the rsp_ channel. A transfer happens on a channel when its
// valid is high and its stall is low. One item is worked on at a time.
// Add, remove and query broadcast the value to every cell; the compare is
// registered in the cells, reduced one more stage, and acted on. The single
// result is loaded into the result register once the reduced compare is in,
// and the next item can transfer after the engine has returned to idle.
// Equal, intersect and union rotate the source set through cell 0 one entry
// per cycle unless rsp_ stalls, and compare it with every entry of the other
// set in parallel, over count_a source entries (plus count_b for union).
// Stream results come out at most one per cycle once the compare pipe has
// filled; each is held back in a pending register so the last can carry last.
// A stalled rsp_ channel freezes the compare pipe and the rotation; the
// result register keeps its payload. The next item may transfer while the
// final result of the previous one still waits.
// Reset (synchronous) empties both sets; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bounded_two_set_engine_unit #(
   parameter int CAPACITY = bts_pkg::DEF_CAPACITY
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bts_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bts_pkg::rsp_type rsp_payload
);
   import bts_pkg::*;

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int NG = (CAPACITY + GROUP - 1) / GROUP;
   localparam logic [COUNT_W-1:0] CAP_COUNT = COUNT_W'(CAPACITY);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_DRAIN = 2'd2;
   localparam logic [1:0] S_FIN   = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [COUNT_W-1:0] a_count_ff, a_count_in;
   logic [COUNT_W-1:0] b_count_ff, b_count_in;
   logic               phase_ff, phase_in;
   logic [IW-1:0]      k_ff, k_in;
   logic               s1_valid_ff, s1_valid_in;
   logic               s2_valid_ff, s2_valid_in;
   logic               pend_valid_ff, pend_valid_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [OP_W-1:0]    op_ff, op_in;
   logic               sel_ff, sel_in;
   logic [DATA_W-1:0]  key_ff, key_in;
   logic [DATA_W-1:0]  s1_val_ff, s1_val_in;
   logic               s1_phase_ff, s1_phase_in;
   logic [DATA_W-1:0]  s2_val_ff, s2_val_in;
   logic               s2_phase_ff, s2_phase_in;
   logic [DATA_W-1:0]  pend_val_ff, pend_val_in;
   logic               eq_ff, eq_in;
   logic               full_ff, full_in;
   logic [COUNT_W-1:0] n_ff, n_in;
   rsp_type            rsp_ff, rsp_in;

   logic               adv;
   logic               single;
   logic               src_b;
   logic [DATA_W-1:0]  head;
   logic [COUNT_W-1:0] src_len;
   logic [COUNT_W-1:0] sel_count;
   logic               last_issue;
   logic               hit;
   logic               s2_last;
   logic               emit;
   logic               load;
   rsp_type            rsp_new;
   cell_ctrl_type      cell_ctrl;

   logic [DATA_W-1:0]  a_vals [CAPACITY];
   logic [DATA_W-1:0]  b_vals [CAPACITY];
   logic [CAPACITY-1:0] match_vec;
   logic [NG-1:0]      s2_grp;
   logic [IW-1:0]      s2_idx;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      localparam int NXT = (i == CAPACITY - 1) ? i : i + 1;
      bts_cell #(
         .INDEX (i)
      ) u_cell (
         .clock   (clock),
         .ctrl    (cell_ctrl),
         .a_next  (a_vals[NXT]),
         .b_next  (b_vals[NXT]),
         .a_first (a_vals[0]),
         .b_first (b_vals[0]),
         .a_value (a_vals[i]),
         .b_value (b_vals[i]),
         .match   (match_vec[i])
      );
   end

   bts_reduce #(
      .CAPACITY (CAPACITY)
   ) u_reduce (
      .clock (clock),
      .en    (adv),
      .match (match_vec),
      .grp   (s2_grp),
      .idx   (s2_idx)
   );

   // Apart from taking a new item in idle, the engine moves only when the result register can take a value.
   assign adv = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in      = state_ff;
      a_count_in    = a_count_ff;
      b_count_in    = b_count_ff;
      phase_in      = phase_ff;
      k_in          = k_ff;
      s1_valid_in   = s1_valid_ff;
      s2_valid_in   = s2_valid_ff;
      pend_valid_in = pend_valid_ff;
      rsp_valid_in  = rsp_valid_ff;
      op_in         = op_ff;
      sel_in        = sel_ff;
      key_in        = key_ff;
      s1_val_in     = s1_val_ff;
      s1_phase_in   = s1_phase_ff;
      s2_val_in     = s2_val_ff;
      s2_phase_in   = s2_phase_ff;
      pend_val_in   = pend_val_ff;
      eq_in         = eq_ff;
      full_in       = full_ff;
      n_in          = n_ff;
      rsp_in        = rsp_ff;

      single     = (op_ff == OP_ADD) || (op_ff == OP_REMOVE) || (op_ff == OP_QUERY);
      src_b      = (op_ff == OP_UNION) && phase_ff;
      head       = src_b ? b_vals[0] : a_vals[0];
      src_len    = src_b ? b_count_ff : a_count_ff;
      sel_count  = sel_ff ? b_count_ff : a_count_ff;
      last_issue = single || (COUNT_W'(k_ff) + COUNT_W'(1) == src_len);
      hit        = |s2_grp;
      s2_last    = (state_ff == S_DRAIN) && !s1_valid_ff;
      emit       = 1'b0;
      load       = 1'b0;

      cell_ctrl.a_op     = CELL_HOLD;
      cell_ctrl.b_op     = CELL_HOLD;
      cell_ctrl.tgt_b    = single ? sel_ff : !src_b;
      cell_ctrl.match_en = adv;
      cell_ctrl.a_count  = a_count_ff;
      cell_ctrl.b_count  = b_count_ff;
      cell_ctrl.idx      = COUNT_W'(s2_idx);
      cell_ctrl.key      = single ? key_ff : head;

      rsp_new.status        = STAT_OK;
      rsp_new.flag          = 1'b0;
      rsp_new.element       = '0;
      rsp_new.element_valid = 1'b0;
      rsp_new.last          = 1'b0;
      rsp_new.set_count     = sel_count;

      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      if (adv) begin
         s1_valid_in = (state_ff == S_SCAN);
         s1_val_in   = single ? key_ff : head;
         s1_phase_in = phase_ff;
         s2_valid_in = s1_valid_ff;
         s2_val_in   = s1_val_ff;
         s2_phase_in = s1_phase_ff;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_payload.operation;
               sel_in   = req_payload.which_set;
               key_in   = req_payload.value;
               k_in     = '0;
               phase_in = 1'b0;
               eq_in    = 1'b1;
               full_in  = 1'b0;
               n_in     = '0;
               case (req_payload.operation)
                  OP_ADD, OP_REMOVE, OP_QUERY: begin
                     state_in = S_SCAN;
                  end
                  OP_EQUAL: begin
                     if (a_count_ff != b_count_ff) begin
                        eq_in    = 1'b0;
                        state_in = S_FIN;
                     end else if (a_count_ff == '0) begin
                        state_in = S_FIN;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  OP_INTERSECT: begin
                     state_in = (a_count_ff == '0) ? S_FIN : S_SCAN;
                  end
                  OP_UNION: begin
                     if (a_count_ff != '0) begin
                        state_in = S_SCAN;
                     end else if (b_count_ff != '0) begin
                        phase_in = 1'b1;
                        state_in = S_SCAN;
                     end else begin
                        state_in = S_FIN;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (adv) begin
               if (!single) begin
                  if (src_b) cell_ctrl.b_op = CELL_ROTATE;
                  else cell_ctrl.a_op = CELL_ROTATE;
               end
               if (last_issue) begin
                  k_in = '0;
                  if (op_ff == OP_UNION && !phase_ff && b_count_ff != '0) begin
                     phase_in = 1'b1;
                  end else begin
                     state_in = S_DRAIN;
                  end
               end else begin
                  k_in = k_ff + IW'(1);
               end
            end
         end
         S_DRAIN: begin
            // Work is done by the compare result handling below.
         end
         S_FIN: begin
            if (adv) begin
               load                  = 1'b1;
               rsp_new.last          = 1'b1;
               rsp_new.flag          = (op_ff == OP_EQUAL) && eq_ff;
               rsp_new.element_valid = pend_valid_ff;
               rsp_new.element       = pend_valid_ff ? pend_val_ff : '0;
               rsp_new.status        = full_ff ? STAT_FULL : STAT_OK;
               pend_valid_in         = 1'b0;
               state_in              = S_IDLE;
            end
         end
      endcase

      // Compare result for the element in the second stage.
      if (adv && s2_valid_ff) begin
         case (op_ff)
            OP_ADD: begin
               if (hit) begin
                  rsp_new.status = STAT_PRESENT;
               end else if (sel_count >= CAP_COUNT) begin
                  rsp_new.status = STAT_FULL;
               end else begin
                  if (sel_ff) begin
                     cell_ctrl.b_op = CELL_WRITE;
                     b_count_in     = b_count_ff + COUNT_W'(1);
                  end else begin
                     cell_ctrl.a_op = CELL_WRITE;
                     a_count_in     = a_count_ff + COUNT_W'(1);
                  end
                  rsp_new.set_count = sel_count + COUNT_W'(1);
               end
            end
            OP_REMOVE: begin
               if (hit) begin
                  if (sel_ff) begin
                     cell_ctrl.b_op = CELL_SHIFT;
                     b_count_in     = b_count_ff - COUNT_W'(1);
                  end else begin
                     cell_ctrl.a_op = CELL_SHIFT;
                     a_count_in     = a_count_ff - COUNT_W'(1);
                  end
                  rsp_new.set_count = sel_count - COUNT_W'(1);
               end else begin
                  rsp_new.status = STAT_ABSENT;
               end
            end
            OP_QUERY: begin
               rsp_new.flag = hit;
            end
            OP_EQUAL: begin
               if (!hit) eq_in = 1'b0;
            end
            OP_INTERSECT: begin
               emit = hit;
            end
            OP_UNION: begin
               // Elements of B that are in A were already sent with A.
               if (!s2_phase_ff) begin
                  emit = 1'b1;
               end else if (!hit) begin
                  if (n_ff >= CAP_COUNT) full_in = 1'b1;
                  else emit = 1'b1;
               end
            end
            default: begin
               emit = 1'b0;
            end
         endcase

         if (single) begin
            load         = 1'b1;
            rsp_new.last = 1'b1;
            state_in     = S_IDLE;
         end else begin
            if (emit) begin
               if (pend_valid_ff) begin
                  load                  = 1'b1;
                  rsp_new.element       = pend_val_ff;
                  rsp_new.element_valid = 1'b1;
               end
               pend_val_in   = s2_val_ff;
               pend_valid_in = 1'b1;
               n_in          = n_ff + COUNT_W'(1);
            end
            if (s2_last) state_in = S_FIN;
         end
      end

      if (load) begin
         rsp_in       = rsp_new;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         a_count_ff    <= '0;
         b_count_ff    <= '0;
         phase_ff      <= 1'b0;
         k_ff          <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         a_count_ff    <= a_count_in;
         b_count_ff    <= b_count_in;
         phase_ff      <= phase_in;
         k_ff          <= k_in;
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s2_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      sel_ff      <= sel_in;
      key_ff      <= key_in;
      s1_val_ff   <= s1_val_in;
      s1_phase_ff <= s1_phase_in;
      s2_val_ff   <= s2_val_in;
      s2_phase_ff <= s2_phase_in;
      pend_val_ff <= pend_val_in;
      eq_ff       <= eq_in;
      full_ff     <= full_in;
      n_ff        <= n_in;
      rsp_ff      <= rsp_in;
   end

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `CHECK_IMPLIES(a_count_bound, clock, reset, 1'b1,
      a_count_ff <= CAP_COUNT && b_count_ff <= CAP_COUNT)
   `CHECK_IMPLIES(idle_pipe_empty, clock, reset, state_ff == S_IDLE,
      !s1_valid_ff && !s2_valid_ff && !pend_valid_ff)
   `CHECK_IMPLIES(distinct_match, clock, reset, s1_valid_ff, $onehot0(match_vec))
   `CHECK_NEXT(fin_loads_last, clock, reset, state_ff == S_FIN && adv,
      rsp_valid_ff && rsp_ff.last)

endmodule
